FILE: rtl/fars_pkg.sv
// Package for the streaming find-and-replace block: shared constants,
// register index codes and the command control type.
// No dependencies.
package fars_pkg;

    // Defaults for the top-level size parameters
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    // Counts of pending bytes and of results per item are at most nine
    localparam int COUNT_W = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Command queue depth
    localparam int QUEUE_DEPTH = 4;

    // Effective lengths after saturation
    typedef struct packed {
        logic [COUNT_W-1:0] plen;
        logic [COUNT_W-1:0] rlen;
    } cfg_len_t;

    // Control part of one command from front to back
    typedef struct packed {
        logic [COUNT_W-1:0] win_cnt;  // leading bytes of the byte list to send
        logic               match;    // replacement follows the window bytes
        logic               last;     // command closes the stream
    } cmd_ctrl_t;

endpackage

FILE: rtl/fars_cfg.sv
// Configuration registers of the find-and-replace block, with length saturation.
// Depends on fars_pkg.
module fars_cfg
    import fars_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = REPLACE_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output logic [7:0]             pattern [PATTERN_MAX],
    output logic [7:0]             replacement [REPLACE_MAX],
    output cfg_len_t               lens
);

    logic [7:0]         pattern_reg [PATTERN_MAX];
    logic [7:0]         replacement_reg [REPLACE_MAX];
    logic [COUNT_W-1:0] plen_reg;
    logic [COUNT_W-1:0] rlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                pattern_reg[i] <= '0;
            for (int i = 0; i < REPLACE_MAX; i++)
                replacement_reg[i] <= '0;
            plen_reg <= COUNT_W'(1);
            rlen_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                        pattern_reg[i] <= cfg_wr_data[8*i +: 8];
                end
                REG_PATTERN_LENGTH:     plen_reg <= cfg_wr_data[COUNT_W-1:0];
                REG_REPLACEMENT_BYTES:
                begin
                    for (int i = 0; i < REPLACE_MAX; i++)
                        replacement_reg[i] <= cfg_wr_data[8*i +: 8];
                end
                REG_REPLACEMENT_LENGTH: rlen_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp lengths: zero pattern acts as one byte, both saturate at their maxima
    always_comb
    begin
        if (plen_reg == '0)
            lens.plen = COUNT_W'(1);
        else if (plen_reg > COUNT_W'(PATTERN_MAX))
            lens.plen = COUNT_W'(PATTERN_MAX);
        else
            lens.plen = plen_reg;

        if (rlen_reg > COUNT_W'(REPLACE_MAX))
            lens.rlen = COUNT_W'(REPLACE_MAX);
        else
            lens.rlen = rlen_reg;
    end

    assign pattern     = pattern_reg;
    assign replacement = replacement_reg;

endmodule

FILE: rtl/fars_front.sv
// Front end of the find-and-replace block: holds the match window, tests it
// against the pattern, issues at most one command per item. Needs fars_pkg.
module fars_front
    import fars_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_input,
    input  logic                        q_full,
    input  logic [7:0]                  pattern [PATTERN_MAX],
    input  cfg_len_t                    lens,
    output logic                        cmd_push,
    output cmd_ctrl_t                   cmd_ctrl,
    output logic [8*(PATTERN_MAX+1)-1:0] cmd_bytes
);

    localparam int EXT_N  = PATTERN_MAX + 1;
    localparam int EXT_IW = $clog2(EXT_N);

    logic [7:0]         win_reg [PATTERN_MAX];
    logic [COUNT_W-1:0] win_cnt_reg;

    logic [7:0]         ext [EXT_N];
    logic [7:0]         new_win [PATTERN_MAX];
    logic [COUNT_W-1:0] drain;
    logic [COUNT_W-1:0] cnt_new;
    logic               eq;
    logic               match;
    logic               accept;
    logic [COUNT_W-1:0] send_cnt;

    assign accept = src_valid && !q_full;

    // Old window followed by the new byte
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
            ext[k] = (COUNT_W'(k) < win_cnt_reg) ? win_reg[k] : data_byte;
        ext[PATTERN_MAX] = data_byte;
    end

    // Oldest bytes to send so that one place is free
    assign drain   = (win_cnt_reg >= lens.plen) ? (win_cnt_reg - lens.plen + COUNT_W'(1))
                                                : '0;
    assign cnt_new = win_cnt_reg - drain + COUNT_W'(1);

    always_comb
    begin
        logic [COUNT_W:0] sel;
        eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            sel = {1'b0, drain} + (COUNT_W+1)'(j);
            if (sel < (COUNT_W+1)'(EXT_N))
                new_win[j] = ext[sel[EXT_IW-1:0]];
            else
                new_win[j] = data_byte;
            if (COUNT_W'(j) < lens.plen && new_win[j] != pattern[j])
                eq = 1'b0;
        end
    end

    // No test when more than one byte was drained after a length change
    assign match = (drain <= COUNT_W'(1)) && (cnt_new == lens.plen) && eq;

    assign send_cnt = end_of_input ? (match ? drain : win_cnt_reg + COUNT_W'(1)) : drain;

    always_comb
    begin
        cmd_ctrl.win_cnt = send_cnt;
        cmd_ctrl.match   = match;
        cmd_ctrl.last    = end_of_input;
        for (int k = 0; k < EXT_N; k++)
            cmd_bytes[8*k +: 8] = ext[k];
    end

    // Items that cause no result are dropped here
    assign cmd_push = accept &&
                      (send_cnt != '0 || (match && lens.rlen != '0) || end_of_input);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_cnt_reg <= '0;
        else if (accept)
            win_cnt_reg <= (match || end_of_input) ? '0 : cnt_new;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= new_win;
    end

endmodule

FILE: rtl/fars_queue.sv
// Short command queue between front and back of the find-and-replace block.
// Depends on fars_pkg for the default depth.
module fars_queue
    import fars_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/fars_back.sv
// Back end of the find-and-replace block, depends on fars_pkg: expands each
// command into results, one per cycle unless stalled, in an output register.
module fars_back
    import fars_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = REPLACE_MAX_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  cmd_ctrl_t                    head_ctrl,
    input  logic [8*(PATTERN_MAX+1)-1:0] head_bytes,
    input  logic [7:0]                   replacement [REPLACE_MAX],
    input  cfg_len_t                     lens,
    output logic                         q_pop,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic [7:0]                   out_byte,
    output logic                         has_byte,
    output logic                         end_of_output
);

    localparam int EXT_N  = PATTERN_MAX + 1;
    localparam int EXT_IW = $clog2(EXT_N);
    localparam int RIW    = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

    logic [COUNT_W-1:0] idx_reg;
    logic               valid_reg;
    logic [7:0]         byte_reg;
    logic               has_reg;
    logic               end_reg;

    logic [7:0]         ext [EXT_N];
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] last_idx;
    logic [COUNT_W-1:0] rel;
    logic [7:0]         byte_next;
    logic               has_next;
    logic               at_last;
    logic               load;

    always_comb
    begin
        for (int k = 0; k < EXT_N; k++)
            ext[k] = head_bytes[8*k +: 8];
    end

    assign total    = head_ctrl.win_cnt + (head_ctrl.match ? lens.rlen : '0);
    assign last_idx = (total == '0) ? '0 : total - COUNT_W'(1);
    assign at_last  = (idx_reg == last_idx);
    assign rel      = idx_reg - head_ctrl.win_cnt;

    // Window bytes first, then the replacement; a bare end marker when empty
    always_comb
    begin
        if (idx_reg < head_ctrl.win_cnt)
        begin
            byte_next = ext[idx_reg[EXT_IW-1:0]];
            has_next  = 1'b1;
        end
        else if (total != '0)
        begin
            byte_next = replacement[rel[RIW-1:0]];
            has_next  = 1'b1;
        end
        else
        begin
            byte_next = '0;
            has_next  = 1'b0;
        end
    end

    assign load  = !valid_reg || !dst_stall;
    assign q_pop = load && !q_empty && at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            if (!q_empty)
                idx_reg <= at_last ? '0 : idx_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
        begin
            byte_reg <= byte_next;
            has_reg  <= has_next;
            end_reg  <= head_ctrl.last && at_last;
        end
    end

    assign dst_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign has_byte      = has_reg;
    assign end_of_output = end_reg;

endmodule

FILE: rtl/find_and_replace_stream.sv
// Top level of the streaming find-and-replace block.
// Depends on fars_pkg, fars_cfg, fars_front, fars_queue and fars_back.
//
// Streaming find-and-replace over a byte string. Bytes come in one per
// transfer on the src channel, with end_of_input on the final byte; every
// leftmost non-overlapping occurrence of the pattern (1 to PATTERN_MAX bytes)
// is replaced by the replacement (0 to REPLACE_MAX bytes) and all other
// bytes pass through in order on the dst channel, one result per transfer.
// The last result of a string carries end_of_output; a string that leaves
// nothing to send closes with one bare marker (has_byte low, out_byte zero).
// Rate: the front takes one byte every cycle while its command queue
// (QUEUE_DEPTH entries) has room; the back sends one result per cycle
// while dst is not stalled, and every command yields at least one result:
// a match up to REPLACE_MAX + 1, a final byte up to PATTERN_MAX + 1.
// Bytes held in the window cost nothing until sent. The dst output
// register decouples the two sides, so a byte is taken while a result
// waits. A byte's first result passes through the command queue and the
// dst output register. Write configuration only while the block is idle;
// pattern and replacement bytes are taken first byte in bits 7..0, lengths
// saturate at the maxima and a pattern length of zero counts as one. The
// window needs no clearing after reset.
module find_and_replace_stream
    import fars_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = REPLACE_MAX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input byte channel
    input  logic                   src_valid,
    output logic                   src_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_input,
    // result channel
    output logic                   dst_valid,
    input  logic                   dst_stall,
    output logic [7:0]             out_byte,
    output logic                   has_byte,
    output logic                   end_of_output
);

    localparam int BYTES_W = 8 * (PATTERN_MAX + 1);
    localparam int CTRL_W  = $bits(cmd_ctrl_t);
    localparam int CMD_W   = CTRL_W + BYTES_W;

    logic [7:0]         pattern [PATTERN_MAX];
    logic [7:0]         replacement [REPLACE_MAX];
    cfg_len_t           lens;

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic               q_full;
    cmd_ctrl_t          push_ctrl;
    logic [BYTES_W-1:0] push_bytes;
    logic [CMD_W-1:0]   head_data;
    cmd_ctrl_t          head_ctrl;
    logic [BYTES_W-1:0] head_bytes;

    // Hold configuration; lengths arrive clamped
    fars_cfg #(
        .PATTERN_MAX(PATTERN_MAX),
        .REPLACE_MAX(REPLACE_MAX)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .pattern    (pattern),
        .replacement(replacement),
        .lens       (lens)
    );

    // Classify each byte against the window and issue a command
    fars_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .data_byte   (data_byte),
        .end_of_input(end_of_input),
        .q_full      (q_full),
        .pattern     (pattern),
        .lens        (lens),
        .cmd_push    (q_push),
        .cmd_ctrl    (push_ctrl),
        .cmd_bytes   (push_bytes)
    );

    // Stall the source only on a full queue
    assign src_stall = q_full;

    fars_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data({push_ctrl, push_bytes}),
        .pop      (q_pop),
        .head_data(head_data),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign head_ctrl  = cmd_ctrl_t'(head_data[CMD_W-1:BYTES_W]);
    assign head_bytes = head_data[BYTES_W-1:0];

    // Expand commands into result transfers
    fars_back #(
        .PATTERN_MAX(PATTERN_MAX),
        .REPLACE_MAX(REPLACE_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_ctrl    (head_ctrl),
        .head_bytes   (head_bytes),
        .replacement  (replacement),
        .lens         (lens),
        .q_pop        (q_pop),
        .dst_valid    (dst_valid),
        .dst_stall    (dst_stall),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .end_of_output(end_of_output)
    );

    // The front never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("command pushed into a full queue");

    // The back never takes from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("command popped from an empty queue");

    // A bare marker closes the stream and carries a zero byte
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !has_byte) |-> (end_of_output && out_byte == 8'd0))
        else $error("bare marker without end of output or with a byte");

endmodule
